// ===== hdl/lss_pkg.sv =====
// Shared constants, command/status types and helpers for the LED scanner sequencer.
package lss_pkg;

	// Strip geometry (4..64 pixels)
	localparam int STRIP_LENGTH = 20;
	localparam int PIX_W        = 6;
	localparam int SIZE_W       = 5;
	localparam int MS_W         = 16;
	localparam int WAIT_W       = 17;
	localparam int COLOR_W      = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int PHASE_W      = 3;
	// eye core size is held to 1 .. STRIP_LENGTH-3 when used
	localparam int E_MAX        = STRIP_LENGTH - 3;
	// signed width for the eye window compares
	localparam int ARITH_W      = 9;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EYE_RED    = 3'd0,
		REG_EYE_GREEN  = 3'd1,
		REG_EYE_BLUE   = 3'd2,
		REG_EYE_SIZE   = 3'd3,
		REG_FRAME_DLY  = 3'd4,
		REG_SWEEP_PSE  = 3'd5
	} cfg_reg_t;

	// sweep kinds
	typedef enum logic [1:0] {
		KIND_RL = 2'd0,
		KIND_LR = 2'd1,
		KIND_OI = 2'd2,
		KIND_IO = 2'd3
	} sweep_kind_t;

	// pixel brightness levels
	typedef enum logic [1:0] {
		LVL_BLACK = 2'd0,
		LVL_DIM   = 2'd1,
		LVL_FULL  = 2'd2
	} level_t;

	// controller -> datapath
	typedef struct packed {
		logic restart;   // reload first sweep, clear wait
		logic tick;      // one millisecond passed
		logic emit_pix;  // load next pixel into the output register
	} lss_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic wait_done;  // wait reaches zero on this tick
		logic last_pix;   // pixel counter is at the last strip position
		logic out_free;   // output register can take a pixel this cycle
	} lss_stat_t;

	function automatic sweep_kind_t kind_of_phase(input logic [PHASE_W-1:0] ph);
		sweep_kind_t k;
		unique case (ph)
			3'd0: k = KIND_RL;
			3'd1: k = KIND_LR;
			3'd2: k = KIND_OI;
			3'd3: k = KIND_IO;
			3'd4: k = KIND_LR;
			3'd5: k = KIND_RL;
			3'd6: k = KIND_OI;
			default: k = KIND_IO;
		endcase
		return k;
	endfunction

	// x/10 for 8-bit x: exact as (x*205)>>11
	function automatic logic [COLOR_W-1:0] div10(input logic [COLOR_W-1:0] x);
		logic [18:0] prod;
		prod = {11'd0, x} * 19'd205;
		return prod[18:11];
	endfunction

endpackage

// ===== hdl/led_scanner_sequencer_core.sv =====
// Top level of the LED scanner sequencer: controller plus datapath.
//
//  channel | signals                                         | role
//  --------+-------------------------------------------------+---------------------------
//  in      | in_valid, in_ready, restart                     | ms tick or restart
//  out     | out_valid, out_ready, pixel_index, pix_*, frame_end | one pixel per transfer
//  cfg     | cfg_we, cfg_index, cfg_data                     | register write, no wait
//
// When an input transfer makes a frame due, the block then sends
// STRIP_LENGTH pixels, one per cycle from the output register, paced by out_ready.
// in_ready is low while a frame is being generated, including any output stalls.
// The last pixel may still sit in the output register when the next tick is taken.
// arst_n clears control state and loads register reset values; no clearing pass.
module led_scanner_sequencer_core import lss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_index,
	output logic [COLOR_W-1:0]    pix_red,
	output logic [COLOR_W-1:0]    pix_green,
	output logic [COLOR_W-1:0]    pix_blue,
	output logic                  frame_end,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lss_cmd_t  cmd;
	lss_stat_t stat;

	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.stat     (stat),
		.cmd      (cmd)
	);

	lss_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.pix_red     (pix_red),
		.pix_green   (pix_green),
		.pix_blue    (pix_blue),
		.frame_end   (frame_end)
	);

endmodule

// ===== hdl/lss_ctrl.sv =====
// Controller state machine: takes ticks, sequences frame emission.
module lss_ctrl import lss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      restart,
	input  lss_stat_t stat,
	output lss_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.restart = restart;
					cmd.tick    = !restart;
					if (restart || stat.wait_done) state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_pix = stat.out_free;
				if (stat.out_free && stat.last_pix) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== hdl/lss_datapath.sv =====
// Datapath: config registers, sweep state, wait counter, pixel shading and output register.
module lss_datapath import lss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  lss_cmd_t              cmd,
	output lss_stat_t             stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_index,
	output logic [COLOR_W-1:0]    pix_red,
	output logic [COLOR_W-1:0]    pix_green,
	output logic [COLOR_W-1:0]    pix_blue,
	output logic                  frame_end
);

	logic [COLOR_W-1:0] red_q, green_q, blue_q;
	logic [SIZE_W-1:0]  size_q;
	logic [MS_W-1:0]    frame_dly_q, sweep_pse_q;

	logic [PHASE_W-1:0] phase_q;
	logic [PIX_W-1:0]   pos_q;
	logic [WAIT_W-1:0]  wait_q;
	logic [PIX_W-1:0]   pix_q;

	logic               out_valid_q;
	logic [PIX_W-1:0]   idx_q;
	logic [COLOR_W-1:0] red_out_q, green_out_q, blue_out_q;
	logic               end_q;

	logic [SIZE_W-1:0]  e_used;
	logic [6:0]         e7, l7, span;
	logic [PIX_W-1:0]   start_rl, start_io, start_next;
	logic [PHASE_W-1:0] phase_next;
	sweep_kind_t        kind, kind_next;
	logic               mirrored, last_frame, frame_done;

	logic signed [ARITH_W-1:0] pp, ii, ee, mm;
	level_t             lvl;

	// saturate eye size
	always_comb begin
		if (size_q == '0)                     e_used = SIZE_W'(1);
		else if (7'(size_q) > 7'(E_MAX))      e_used = SIZE_W'(E_MAX);
		else                                  e_used = size_q;
	end

	assign e7       = 7'(e_used);
	assign l7       = 7'(STRIP_LENGTH);
	assign span     = l7 - e7;
	assign start_rl = PIX_W'(span - 7'd2);
	assign start_io = PIX_W'(span >> 1);

	assign kind       = kind_of_phase(phase_q);
	assign mirrored   = (kind == KIND_OI) || (kind == KIND_IO);
	assign phase_next = phase_q + PHASE_W'(1);
	assign kind_next  = kind_of_phase(phase_next);

	always_comb begin
		unique case (kind_next)
			KIND_RL: start_next = start_rl;
			KIND_IO: start_next = start_io;
			default: start_next = '0;
		endcase
	end

	always_comb begin
		unique case (kind)
			KIND_RL: last_frame = (pos_q <= PIX_W'(1));
			KIND_LR: last_frame = (7'(pos_q) + 7'd1 >= span - 7'd2);
			KIND_OI: last_frame = (7'(pos_q) >= (span >> 1));
			default: last_frame = (pos_q == '0);
		endcase
	end

	// eye window for the current pixel; the mirrored eye wins on overlap
	assign pp = ARITH_W'(pix_q);
	assign ii = ARITH_W'(pos_q);
	assign ee = ARITH_W'(e_used);
	assign mm = ARITH_W'(STRIP_LENGTH) - ii;

	always_comb begin
		priority if (mirrored && pp == mm - ee - 1)             lvl = LVL_DIM;
		else if (mirrored && pp >= mm - ee && pp <= mm - 1)     lvl = LVL_FULL;
		else if (mirrored && pp == mm)                          lvl = LVL_DIM;
		else if (pp == ii + ee + 1)                             lvl = LVL_DIM;
		else if (pp >= ii + 1 && pp <= ii + ee)                 lvl = LVL_FULL;
		else if (pp == ii)                                      lvl = LVL_DIM;
		else                                                    lvl = LVL_BLACK;
	end

	assign frame_done = cmd.emit_pix && stat.last_pix;

	assign stat.wait_done = (wait_q <= WAIT_W'(1));
	assign stat.last_pix  = (pix_q == PIX_W'(STRIP_LENGTH - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= 8'd255;
			green_q     <= '0;
			blue_q      <= '0;
			size_q      <= SIZE_W'(8);
			frame_dly_q <= MS_W'(10);
			sweep_pse_q <= MS_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EYE_RED:   red_q       <= cfg_data[COLOR_W-1:0];
				REG_EYE_GREEN: green_q     <= cfg_data[COLOR_W-1:0];
				REG_EYE_BLUE:  blue_q      <= cfg_data[COLOR_W-1:0];
				REG_EYE_SIZE:  size_q      <= cfg_data[SIZE_W-1:0];
				REG_FRAME_DLY: frame_dly_q <= cfg_data[MS_W-1:0];
				REG_SWEEP_PSE: sweep_pse_q <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// sweep state and wait counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= PIX_W'(STRIP_LENGTH - 10);
			wait_q  <= '0;
			pix_q   <= '0;
		end else begin
			if (cmd.restart) begin
				phase_q <= '0;
				pos_q   <= start_rl;
				wait_q  <= '0;
			end else if (cmd.tick && wait_q != '0) begin
				wait_q <= wait_q - WAIT_W'(1);
			end
			if (cmd.emit_pix) begin
				pix_q <= frame_done ? '0 : pix_q + PIX_W'(1);
			end
			if (frame_done) begin
				if (last_frame) begin
					wait_q  <= WAIT_W'(frame_dly_q) + WAIT_W'(sweep_pse_q);
					phase_q <= phase_next;
					pos_q   <= start_next;
				end else begin
					wait_q <= WAIT_W'(frame_dly_q);
					if (kind == KIND_RL || kind == KIND_IO) pos_q <= pos_q - PIX_W'(1);
					else                                     pos_q <= pos_q + PIX_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pix) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pix) begin
			idx_q <= pix_q;
			end_q <= stat.last_pix;
			unique case (lvl)
				LVL_FULL: begin
					red_out_q   <= red_q;
					green_out_q <= green_q;
					blue_out_q  <= blue_q;
				end
				LVL_DIM: begin
					red_out_q   <= div10(red_q);
					green_out_q <= div10(green_q);
					blue_out_q  <= div10(blue_q);
				end
				default: begin
					red_out_q   <= '0;
					green_out_q <= '0;
					blue_out_q  <= '0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = idx_q;
	assign pix_red     = red_out_q;
	assign pix_green   = green_out_q;
	assign pix_blue    = blue_out_q;
	assign frame_end   = end_q;

endmodule
